[rtl/core/rphd_pkg.sv]
// ----------------------------------------------------------------------------
// rphd_pkg
// Shared types and constants for the radio packet header deframer.
// ----------------------------------------------------------------------------
`default_nettype none

package rphd_pkg;

    localparam int unsigned ADDR_W   = 10;
    localparam int unsigned BYTE_W   = 8;
    localparam int unsigned LEN_W    = 7;
    localparam int unsigned REM_W    = 6;
    localparam int unsigned CFG_IDX_W = 1;

    localparam logic [LEN_W-1:0]  LEN_CLAMP    = 7'd66;
    localparam logic [LEN_W-1:0]  HEADER_BYTES = 7'd3;
    localparam logic [BYTE_W-1:0] CTL_TARGET_HI     = 8'h0C;
    localparam logic [BYTE_W-1:0] CTL_SENDER_HI     = 8'h03;
    localparam logic [BYTE_W-1:0] CTL_ACK_RECEIVED  = 8'h80;
    localparam logic [BYTE_W-1:0] CTL_ACK_REQUESTED = 8'h40;

    localparam logic [ADDR_W-1:0] NODE_ADDRESS_RESET      = 10'd0;
    localparam logic [ADDR_W-1:0] BROADCAST_ADDRESS_RESET = 10'd255;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_NODE_ADDRESS      = 1'b0,
        CFG_BROADCAST_ADDRESS = 1'b1
    } cfg_index_t;

    typedef enum logic [1:0] {
        KIND_HEADER  = 2'd0,
        KIND_PAYLOAD = 2'd1,
        KIND_REJECT  = 2'd2
    } kind_t;

    typedef struct packed {
        logic              frame_start;
        logic [BYTE_W-1:0] byte_value;
    } rx_item_t;

    typedef struct packed {
        logic     valid;
        rx_item_t item;
    } stage_t;

    typedef struct packed {
        kind_t             kind;
        logic [ADDR_W-1:0] target_id;
        logic [ADDR_W-1:0] sender_id;
        logic              is_ack;
        logic              ack_wanted;
        logic [REM_W-1:0]  payload_length;
        logic [BYTE_W-1:0] payload_byte;
        logic              last;
    } res_item_t;

    typedef struct packed {
        logic      valid;
        res_item_t item;
    } result_t;

endpackage

`default_nettype wire

[rtl/core/rphd_if.sv]
// ----------------------------------------------------------------------------
// rphd_if
// Stream channels of the deframer: received bytes in, parsed results out.
// ----------------------------------------------------------------------------
`default_nettype none

interface rphd_rx_if;
    logic       valid;
    logic       ready;
    logic       frame_start;
    logic [7:0] byte_value;

    modport source (output valid, output frame_start, output byte_value, input ready);
    modport sink   (input valid, input frame_start, input byte_value, output ready);
endinterface

interface rphd_res_if;
    logic       valid;
    logic       ready;
    logic [1:0] kind;
    logic [9:0] target_id;
    logic [9:0] sender_id;
    logic       is_ack;
    logic       ack_wanted;
    logic [5:0] payload_length;
    logic [7:0] payload_byte;
    logic       last;

    modport source (
        output valid, output kind, output target_id, output sender_id,
        output is_ack, output ack_wanted, output payload_length,
        output payload_byte, output last, input ready
    );
    modport sink (
        input valid, input kind, input target_id, input sender_id,
        input is_ack, input ack_wanted, input payload_length,
        input payload_byte, input last, output ready
    );
endinterface

`default_nettype wire

[rtl/core/radio_packet_header_deframer.sv]
// ----------------------------------------------------------------------------
// radio_packet_header_deframer
// Path: input register, combinational parser, then the result register.
// Throughput: one byte per cycle; stalled results hold a full input register.
// Reset: asynchronous; clears valids and parser state, restores config.
// Top level: parses length, address, control bytes; forwards payload bytes.
// ----------------------------------------------------------------------------
`default_nettype none

module radio_packet_header_deframer (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    rphd_rx_if.sink                                rx,
    rphd_res_if.source                             res,
    input  wire logic                              cfg_wr_en,
    input  wire logic [rphd_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  wire logic [rphd_pkg::ADDR_W-1:0]       cfg_data
);
    import rphd_pkg::*;

    logic [ADDR_W-1:0] node_address_reg;
    logic [ADDR_W-1:0] broadcast_address_reg;

    rx_item_t  rx_item;
    stage_t    stage;
    result_t   result;
    res_item_t res_item;
    logic      load_ok;
    logic      advance;
    logic      fire;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            node_address_reg      <= NODE_ADDRESS_RESET;
            broadcast_address_reg <= BROADCAST_ADDRESS_RESET;
        end
        else if (cfg_wr_en)
        begin
            case (cfg_index_t'(cfg_index))
                CFG_NODE_ADDRESS:      node_address_reg      <= cfg_data;
                CFG_BROADCAST_ADDRESS: broadcast_address_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    assign rx_item.frame_start = rx.frame_start;
    assign rx_item.byte_value  = rx.byte_value;

    assign fire     = stage.valid && load_ok;
    assign advance  = !stage.valid || load_ok;
    assign rx.ready = advance;

    rphd_in_reg u_in_reg (
        .clk      (clk),
        .rst_n    (rst_n),
        .advance  (advance),
        .rx_valid (rx.valid),
        .rx_item  (rx_item),
        .stage    (stage)
    );

    rphd_parser u_parser (
        .clk               (clk),
        .rst_n             (rst_n),
        .fire              (fire),
        .item              (stage.item),
        .node_address      (node_address_reg),
        .broadcast_address (broadcast_address_reg),
        .result            (result)
    );

    rphd_out_reg u_out_reg (
        .clk       (clk),
        .rst_n     (rst_n),
        .fire      (fire),
        .result    (result),
        .res_ready (res.ready),
        .res_valid (res.valid),
        .res_item  (res_item),
        .load_ok   (load_ok)
    );

    assign res.kind           = res_item.kind;
    assign res.target_id      = res_item.target_id;
    assign res.sender_id      = res_item.sender_id;
    assign res.is_ack         = res_item.is_ack;
    assign res.ack_wanted     = res_item.ack_wanted;
    assign res.payload_length = res_item.payload_length;
    assign res.payload_byte   = res_item.payload_byte;
    assign res.last           = res_item.last;

endmodule

`default_nettype wire

[rtl/core/rphd_in_reg.sv]
// ----------------------------------------------------------------------------
// rphd_in_reg
// Input register: captures one received byte per transfer.
// ----------------------------------------------------------------------------
`default_nettype none

module rphd_in_reg (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             advance,
    input  wire logic             rx_valid,
    input  wire rphd_pkg::rx_item_t rx_item,
    output rphd_pkg::stage_t      stage
);
    import rphd_pkg::*;

    logic     valid_reg;
    rx_item_t item_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            valid_reg <= rx_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance && rx_valid)
        begin
            item_reg <= rx_item;
        end
    end

    assign stage.valid = valid_reg;
    assign stage.item  = item_reg;

endmodule

`default_nettype wire

[rtl/core/rphd_parser.sv]
// ----------------------------------------------------------------------------
// rphd_parser
// Header parser: tracks byte position and forms one result per control or payload byte.
// ----------------------------------------------------------------------------
`default_nettype none

module rphd_parser (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           fire,
    input  wire rphd_pkg::rx_item_t             item,
    input  wire logic [rphd_pkg::ADDR_W-1:0]    node_address,
    input  wire logic [rphd_pkg::ADDR_W-1:0]    broadcast_address,
    output rphd_pkg::result_t                   result
);
    import rphd_pkg::*;

    typedef enum logic [2:0] {
        POS_IDLE    = 3'd0,
        POS_TARGET  = 3'd1,
        POS_SENDER  = 3'd2,
        POS_CONTROL = 3'd3,
        POS_PAYLOAD = 3'd4
    } pos_t;

    pos_t              pos_reg, pos_next;
    logic [LEN_W-1:0]  len_reg, len_next;
    logic [BYTE_W-1:0] tgt_lo_reg, tgt_lo_next;
    logic [BYTE_W-1:0] snd_lo_reg, snd_lo_next;
    logic [REM_W-1:0]  rem_reg, rem_next;

    logic [BYTE_W-1:0] b;
    logic [ADDR_W-1:0] tgt;
    logic [ADDR_W-1:0] snd;
    logic [LEN_W-1:0]  len_payload;
    logic [REM_W-1:0]  rem_dec;
    logic              reject;

    assign b           = item.byte_value;
    assign tgt         = {|(b & CTL_TARGET_HI) ? b[3:2] : 2'b00, tgt_lo_reg};
    assign snd         = {b[1:0] & CTL_SENDER_HI[1:0], snd_lo_reg};
    assign len_payload = len_reg - HEADER_BYTES;
    assign reject      = (len_reg < HEADER_BYTES) ||
                         ((tgt != node_address) && (tgt != broadcast_address));
    assign rem_dec     = (rem_reg != '0) ? rem_reg - 1'b1 : rem_reg;

    always_comb
    begin
        pos_next    = pos_reg;
        len_next    = len_reg;
        tgt_lo_next = tgt_lo_reg;
        snd_lo_next = snd_lo_reg;
        rem_next    = rem_reg;
        result      = '0;
        result.item.kind = KIND_HEADER;

        if (item.frame_start)
        begin
            len_next = (b > BYTE_W'(LEN_CLAMP)) ? LEN_CLAMP : b[LEN_W-1:0];
            pos_next = POS_TARGET;
            rem_next = '0;
        end
        else
        begin
            case (pos_reg)
                POS_TARGET:
                begin
                    tgt_lo_next = b;
                    pos_next    = POS_SENDER;
                end
                POS_SENDER:
                begin
                    snd_lo_next = b;
                    pos_next    = POS_CONTROL;
                end
                POS_CONTROL:
                begin
                    result.valid          = 1'b1;
                    result.item.target_id = tgt;
                    result.item.sender_id = snd;
                    result.item.last      = 1'b1;
                    if (reject)
                    begin
                        result.item.kind = KIND_REJECT;
                        pos_next         = POS_IDLE;
                    end
                    else
                    begin
                        rem_next                   = len_payload[REM_W-1:0];
                        result.item.kind           = KIND_HEADER;
                        result.item.is_ack         = |(b & CTL_ACK_RECEIVED);
                        result.item.ack_wanted     = |(b & CTL_ACK_REQUESTED);
                        result.item.payload_length = len_payload[REM_W-1:0];
                        result.item.last           = (len_payload[REM_W-1:0] == '0);
                        pos_next = (len_payload[REM_W-1:0] == '0) ? POS_IDLE : POS_PAYLOAD;
                    end
                end
                POS_PAYLOAD:
                begin
                    result.valid             = 1'b1;
                    result.item.kind         = KIND_PAYLOAD;
                    result.item.payload_byte = b;
                    rem_next                 = rem_dec;
                    result.item.last         = (rem_dec == '0);
                    if (rem_dec == '0)
                    begin
                        pos_next = POS_IDLE;
                    end
                end
                default:
                begin
                    pos_next = POS_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg    <= POS_IDLE;
            len_reg    <= '0;
            tgt_lo_reg <= '0;
            snd_lo_reg <= '0;
            rem_reg    <= '0;
        end
        else if (fire)
        begin
            pos_reg    <= pos_next;
            len_reg    <= len_next;
            tgt_lo_reg <= tgt_lo_next;
            snd_lo_reg <= snd_lo_next;
            rem_reg    <= rem_next;
        end
    end

endmodule

`default_nettype wire

[rtl/core/rphd_out_reg.sv]
// ----------------------------------------------------------------------------
// rphd_out_reg
// Result register: holds one parsed result until its transfer completes.
// ----------------------------------------------------------------------------
`default_nettype none

module rphd_out_reg (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                fire,
    input  wire rphd_pkg::result_t   result,
    input  wire logic                res_ready,
    output logic                     res_valid,
    output rphd_pkg::res_item_t      res_item,
    output logic                     load_ok
);
    import rphd_pkg::*;

    logic      valid_reg;
    res_item_t item_reg;

    assign load_ok = !valid_reg || res_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (load_ok)
        begin
            valid_reg <= fire && result.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (fire && result.valid)
        begin
            item_reg <= result.item;
        end
    end

    assign res_valid = valid_reg;
    assign res_item  = item_reg;

endmodule

`default_nettype wire
